/* design/gced_pkg.sv */
// types, constants and level functions shared by the change-event detector
package gced_pkg;

    localparam int NUM_BUTTONS  = 14;
    localparam int NUM_TRIGGERS = 2;
    localparam int NUM_AXES     = 4;
    localparam int NUM_SLOTS    = NUM_BUTTONS + NUM_TRIGGERS + NUM_AXES;
    localparam int SLOT_W       = $clog2(NUM_SLOTS);
    localparam int QUEUE_DEPTH  = 2;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

    localparam logic [4:0]  ID_TRIGGER_BASE = 5'd14;
    localparam logic [4:0]  ID_AXIS_BASE    = 5'd16;
    localparam logic [15:0] LEVEL_ONE       = 16'd32768;

    localparam logic [7:0]  THRESHOLD_RESET = 8'd30;
    localparam logic [14:0] DEADZONE_RESET  = 15'd8689;

    localparam int PADDR_W = 3;
    localparam logic REG_TRIGGER_THRESHOLD = 1'b0;
    localparam logic REG_STICK_DEADZONE    = 1'b1;

    typedef struct packed {
        logic [7:0]  trigger_threshold;
        logic [14:0] stick_deadzone;
    } cfg_t;

    typedef struct packed {
        logic [NUM_SLOTS-1:0]    mask;
        logic [NUM_BUTTONS-1:0]  buttons;
        logic [NUM_TRIGGERS-1:0][7:0]  triggers;
        logic [NUM_AXES-1:0][15:0]     axes;
        logic [NUM_AXES-1:0]     axis_pos;
    } rpt_t;

    typedef struct packed {
        logic full;
        logic empty;
    } qstat_t;

    // round(v * 32768 / 255)
    function automatic logic [15:0] trigger_level(input logic [7:0] v);
        logic [14:0] y;
        logic [15:0] s;
        logic [7:0]  q;
        y = {v, 7'd0} + 15'd127;
        s = {1'b0, y} + 16'd1 + {8'd0, y[14:7] >> 1};
        q = s[15:8];
        return {1'b0, v, 7'd0} + {8'd0, q};
    endfunction

    // round(m * 32768 / 32767) for m below 32768
    function automatic logic [15:0] axis_pos_level(input logic [15:0] m);
        return m + {15'd0, m[14]};
    endfunction

endpackage

/* design/gced_cfg.sv */
// configuration register file behind the apb-style port
module gced_cfg
    import gced_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output cfg_t               cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;
    logic reg_sel;

    assign pready  = 1'b1;
    assign reg_sel = paddr[2];
    assign cfg     = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (psel && penable && pwrite)
        begin
            case (reg_sel)
                REG_TRIGGER_THRESHOLD: cfg_next.trigger_threshold = pwdata[7:0];
                REG_STICK_DEADZONE:    cfg_next.stick_deadzone    = pwdata[14:0];
                default:               cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            REG_TRIGGER_THRESHOLD: prdata = {24'd0, cfg_reg.trigger_threshold};
            REG_STICK_DEADZONE:    prdata = {17'd0, cfg_reg.stick_deadzone};
            default:               prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.trigger_threshold <= THRESHOLD_RESET;
            cfg_reg.stick_deadzone    <= DEADZONE_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

/* design/gced_front.sv */
// front end: accepts reports, drops stale ones, builds the change mask
module gced_front
    import gced_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] packet_number,
    input  logic [15:0] button_word,
    input  logic [7:0]  trigger_l,
    input  logic [7:0]  trigger_r,
    input  logic signed [15:0] left_stick_x,
    input  logic signed [15:0] left_stick_y,
    input  logic signed [15:0] right_stick_x,
    input  logic signed [15:0] right_stick_y,
    input  qstat_t      qstat,
    output logic        push,
    output rpt_t        push_data
);

    logic [31:0]                  packet_reg;
    logic [NUM_BUTTONS-1:0]       buttons_reg;
    logic [NUM_TRIGGERS-1:0][7:0] triggers_reg;
    logic [NUM_AXES-1:0][15:0]    axes_reg;

    logic                         take;
    logic [NUM_BUTTONS-1:0]       btn_new;
    logic [NUM_TRIGGERS-1:0][7:0] trig_new;
    logic [NUM_AXES-1:0][15:0]    axes_new;
    rpt_t                         rpt;

    assign in_ready = !qstat.full;
    assign take     = in_valid && in_ready && (packet_number > packet_reg);
    assign btn_new  = {button_word[15:12], button_word[9:0]};
    assign trig_new = {trigger_r, trigger_l};
    assign axes_new = {right_stick_y, right_stick_x, left_stick_y, left_stick_x};

    always_comb
    begin
        rpt          = '0;
        rpt.buttons  = btn_new;
        rpt.triggers = trig_new;
        rpt.axes     = axes_new;
        rpt.mask[NUM_BUTTONS-1:0] = btn_new ^ buttons_reg;
        for (int t = 0; t < NUM_TRIGGERS; t++)
        begin
            rpt.mask[NUM_BUTTONS + t] = (trig_new[t] != triggers_reg[t]);
        end
        for (int a = 0; a < NUM_AXES; a++)
        begin
            rpt.mask[NUM_BUTTONS + NUM_TRIGGERS + a] = (axes_new[a] != axes_reg[a]);
            if (axes_new[a] != 16'd0)
            begin
                rpt.axis_pos[a] = !axes_new[a][15];
            end
            else
            begin
                // zero releases the direction last used
                rpt.axis_pos[a] = !axes_reg[a][15] && (axes_reg[a] != 16'd0);
            end
        end
    end

    assign push      = take && (rpt.mask != '0);
    assign push_data = rpt;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            packet_reg   <= '0;
            buttons_reg  <= '0;
            triggers_reg <= '0;
            axes_reg     <= '0;
        end
        else if (take)
        begin
            packet_reg   <= packet_number;
            buttons_reg  <= btn_new;
            triggers_reg <= trig_new;
            axes_reg     <= axes_new;
        end
    end

endmodule

/* design/gced_queue.sv */
// short report queue between front end and event generator
module gced_queue
    import gced_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  rpt_t   push_data,
    input  logic   pop,
    output rpt_t   head_data,
    output qstat_t qstat
);

    rpt_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;

    assign head_data   = entry_reg[rd_ptr_reg];
    assign qstat.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign qstat.empty = (count_reg == '0);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

/* design/gced_back.sv */
// event generator: walks the change mask, one event word per cycle while the output is not stalled
module gced_back
    import gced_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  rpt_t        head_data,
    input  qstat_t      qstat,
    input  cfg_t        cfg,
    output logic        pop,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [4:0]  control_id,
    output logic        is_pressed,
    output logic [15:0] level,
    output logic        last_event
);

    logic                 work_active_reg;
    logic                 work_active_next;
    logic [NUM_SLOTS-1:0] work_mask_reg;
    logic [NUM_SLOTS-1:0] work_mask_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic [4:0]           id_reg;
    logic                 pressed_reg;
    logic [15:0]          level_reg;
    logic                 last_reg;

    logic [NUM_SLOTS-1:0] cur_mask;
    logic [NUM_SLOTS-1:0] low_bit;
    logic [NUM_SLOTS-1:0] rest_mask;
    logic [SLOT_W-1:0]    slot;
    logic                 emit;
    logic [4:0]           ev_id;
    logic                 ev_pressed;
    logic [15:0]          ev_level;
    logic [15:0]          ax;
    logic [15:0]          mag;
    logic                 ax_pos;
    logic [1:0]           ax_idx;
    logic                 tr_idx;

    assign cur_mask  = work_active_reg ? work_mask_reg : head_data.mask;
    assign low_bit   = cur_mask & (~cur_mask + 1'b1);
    assign rest_mask = cur_mask & ~low_bit;
    assign emit      = !qstat.empty && (!out_valid_reg || out_ready);
    assign pop       = emit && (rest_mask == '0);

    always_comb
    begin
        slot = '0;
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            if (low_bit[i])
            begin
                slot = slot | SLOT_W'(i);
            end
        end
    end

    always_comb
    begin
        tr_idx     = slot[0];
        ax_idx     = 2'(slot - SLOT_W'(NUM_BUTTONS + NUM_TRIGGERS));
        ax         = head_data.axes[ax_idx];
        ax_pos     = head_data.axis_pos[ax_idx];
        mag        = ax[15] ? (~ax + 16'd1) : ax;
        ev_id      = 5'(slot);
        ev_pressed = 1'b0;
        ev_level   = '0;
        case (slot) inside
            [0:NUM_BUTTONS-1]:
            begin
                ev_pressed = head_data.buttons[slot[3:0]];
                ev_level   = ev_pressed ? LEVEL_ONE : 16'd0;
            end
            [NUM_BUTTONS:NUM_BUTTONS+NUM_TRIGGERS-1]:
            begin
                ev_pressed = head_data.triggers[tr_idx] > cfg.trigger_threshold;
                ev_level   = trigger_level(head_data.triggers[tr_idx]);
            end
            default:
            begin
                ev_id = ID_AXIS_BASE + {2'd0, ax_idx, 1'b0} + {4'd0, ax_pos};
                if (ax == 16'd0)
                begin
                    ev_pressed = 1'b0;
                    ev_level   = 16'd0;
                end
                else
                begin
                    ev_pressed = mag > {1'b0, cfg.stick_deadzone};
                    ev_level   = ax[15] ? mag : axis_pos_level(mag);
                end
            end
        endcase
    end

    always_comb
    begin
        work_active_next = work_active_reg;
        work_mask_next   = work_mask_reg;
        out_valid_next   = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (emit)
        begin
            out_valid_next   = 1'b1;
            work_active_next = (rest_mask != '0);
            work_mask_next   = rest_mask;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            work_active_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            work_active_reg <= work_active_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        work_mask_reg <= work_mask_next;
        if (emit)
        begin
            id_reg      <= ev_id;
            pressed_reg <= ev_pressed;
            level_reg   <= ev_level;
            last_reg    <= (rest_mask == '0);
        end
    end

    assign out_valid  = out_valid_reg;
    assign control_id = id_reg;
    assign is_pressed = pressed_reg;
    assign level      = level_reg;
    assign last_event = last_reg;

endmodule

/* design/gamepad_change_event_detector.sv */
// top level of the gamepad change-event detector
// A report is taken whenever the two-entry report queue has room; stale
// reports and reports without changes leave no trace downstream. Each queued report
// then yields one event word per cycle while the output is accepted, from 1 up to 20
// of them in control order, with no gap between reports; last_event marks the final
// word of each report. The sustained rate is set by the event generator, one event
// word per cycle, and by the output handshake.
module gamepad_change_event_detector
    import gced_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [31:0]        packet_number,
    input  logic [15:0]        button_word,
    input  logic [7:0]         trigger_l,
    input  logic [7:0]         trigger_r,
    input  logic signed [15:0] left_stick_x,
    input  logic signed [15:0] left_stick_y,
    input  logic signed [15:0] right_stick_x,
    input  logic signed [15:0] right_stick_y,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [4:0]         control_id,
    output logic               is_pressed,
    output logic [15:0]        level,
    output logic               last_event
);

    cfg_t   cfg;
    qstat_t qstat;
    logic   push;
    rpt_t   push_data;
    logic   pop;
    rpt_t   head_data;

    gced_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    gced_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .packet_number (packet_number),
        .button_word   (button_word),
        .trigger_l     (trigger_l),
        .trigger_r     (trigger_r),
        .left_stick_x  (left_stick_x),
        .left_stick_y  (left_stick_y),
        .right_stick_x (right_stick_x),
        .right_stick_y (right_stick_y),
        .qstat         (qstat),
        .push          (push),
        .push_data     (push_data)
    );

    gced_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head_data (head_data),
        .qstat     (qstat)
    );

    gced_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_data  (head_data),
        .qstat      (qstat),
        .cfg        (cfg),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .control_id (control_id),
        .is_pressed (is_pressed),
        .level      (level),
        .last_event (last_event)
    );

endmodule
